// ===== hdl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;

  // Request codes carried in the func field.
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    C_HOLD,
    C_LOAD,
    C_FROM_LEFT,
    C_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cap;   // capture the compare against the key
  } cell_ctl_t;

endpackage

// ===== hdl/bdq_cell.sv =====
`timescale 1ns / 1ps

module bdq_cell (
  input  logic                              clk,
  input  bdq_pkg::cell_ctl_t                ctl,
  input  logic signed [bdq_pkg::DATA_W-1:0] left_data,
  input  logic signed [bdq_pkg::DATA_W-1:0] right_data,
  input  logic signed [bdq_pkg::DATA_W-1:0] load_data,
  input  logic signed [bdq_pkg::DATA_W-1:0] key,
  output logic signed [bdq_pkg::DATA_W-1:0] data,
  output logic                              match
);
  import bdq_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      C_LOAD:       data <= load_data;
      C_FROM_LEFT:  data <= left_data;
      C_FROM_RIGHT: data <= right_data;
      default:      data <= data;
    endcase
    if (ctl.cap) begin
      match <= (data == key);
    end
  end

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// Each request item is accepted in the idle state. Every cell registers its compare
// at the accepting edge; the update state then selects the result, loads it into the
// output register and shifts or writes the cells. No new item is taken until that completes.
// A result still waiting in the output register holds the next request in its
// update cycle, so the input stalls until the receiver takes that result.
// Reset (synchronous, active high) empties the deque; cell contents are kept.

module bounded_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // func [2:0], value [34:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status [1:0], data_out [33:2],
                                 // position [37:34], occupancy [42:38], zero pad
);
  import bdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // The deque is a row of cells with the front always in cell 0 and the
  // element count saying how many cells, from cell 0, hold live data.
  // Pushing at the front shifts every cell one place towards the back,
  // popping at the front shifts them one place towards the front. The back
  // end is written or dropped in place, so it only moves the count.

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [FUNC_W-1:0]    func_q;
  logic signed [DATA_W-1:0] value_q;

  logic                 acc, go;
  logic [FUNC_W-1:0]    in_func;
  logic signed [DATA_W-1:0] in_value;

  cell_ctl_t                ctl       [DEPTH];
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] left_in   [DEPTH];
  logic signed [DATA_W-1:0] right_in  [DEPTH];
  logic [DEPTH-1:0]         match;

  logic                     full, empty;
  logic [STATUS_W-1:0]      res_status;
  logic signed [DATA_W-1:0] res_data;
  logic [IW-1:0]            res_pos;
  logic                     hit;
  logic [IW-1:0]            hit_pos;
  logic signed [DATA_W-1:0] back_data;
  logic [POS_W+IW-1:0]      pos_ext;
  logic [OCC_W+CW-1:0]      occ_ext;

  assign in_func  = s_tdata[2:0];
  assign in_value = s_tdata[34:3];

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  // The update step completes only when the output register is free or
  // being emptied in the same cycle.
  assign go       = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Cell chain. Cell 0 takes the pushed value from its left; the last cell
  // takes zero from its right, which only ever lands in a dead cell.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = value_q;
    end else begin : g_mid
      assign left_in[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_inner
      assign right_in[g] = cell_data[g+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .left_data  (left_in[g]),
      .right_data (right_in[g]),
      .load_data  (value_q),
      .key        (in_value),
      .data       (cell_data[g]),
      .match      (match[g])
    );
  end

  // Per-cell control: each cell captures its compare when a request item is
  // accepted, and moves or loads only when the request completes.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].cap = acc;
      ctl[i].op  = C_HOLD;
      if (go) begin
        case (func_q)
          FN_PUSH_FRONT: begin
            if (!full) ctl[i].op = C_FROM_LEFT;
          end
          FN_PUSH_BACK: begin
            if (!full && (count == CW'(i))) ctl[i].op = C_LOAD;
          end
          FN_POP_FRONT: begin
            if (!empty) ctl[i].op = C_FROM_RIGHT;
          end
          default: ctl[i].op = C_HOLD;
        endcase
      end
    end
  end

  // Result selection from the registered compares and the back cell.
  always_comb begin
    hit       = 1'b0;
    hit_pos   = '0;
    back_data = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i] && (CW'(i) < count)) begin
        hit     = 1'b1;
        hit_pos = IW'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i + 1) == count) back_data = back_data | cell_data[i];
    end

    res_status = STAT_OK;
    res_data   = '0;
    res_pos    = '0;
    count_next = count;
    case (func_q)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (full) res_status = STAT_FULL;
        else      count_next = count + CW'(1);
      end
      FN_POP_FRONT: begin
        if (empty) begin
          res_status = STAT_EMPTY;
        end else begin
          res_data   = cell_data[0];
          count_next = count - CW'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          res_status = STAT_EMPTY;
        end else begin
          res_data   = back_data;
          count_next = count - CW'(1);
        end
      end
      FN_SEARCH: begin
        if (hit) begin
          res_data = value_q;
          res_pos  = hit_pos;
        end else begin
          res_status = STAT_NOTFOUND;
        end
      end
      default: res_status = STAT_OK;   // unused codes leave the deque alone
    endcase

    pos_ext = {{POS_W{1'b0}}, res_pos};
    occ_ext = {{OCC_W{1'b0}}, count_next};
  end

  // Sequencer: one request at a time, compare cycle then update cycle.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc) state_next = ST_EXEC;
      ST_EXEC: if (go)  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      func_q  <= in_func;
      value_q <= in_value;
    end
    if (go) begin
      m_tdata <= {5'd0, occ_ext[OCC_W-1:0], pos_ext[POS_W-1:0], res_data, res_status};
    end
  end

  // The element count never passes the number of cells.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("element count beyond capacity");

  // An accepted request always moves the sequencer to its update cycle.
  assert property (@(posedge clk) disable iff (rst) acc |=> (state == ST_EXEC))
    else $error("accepted item not taken into execution");

  // A refused push leaves the deque full.
  assert property (@(posedge clk) disable iff (rst)
      (go && (res_status == STAT_FULL)) |=> (count == CW'(DEPTH)))
    else $error("full status reported while not full");

  // A completed request always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst) go |=> m_tvalid)
    else $error("completed request produced no result");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bdq_pkg::*;

  localparam int DQ_DEPTH = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_AFTER = 120;   // accepted items before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT = 250;     // random item at which the sender waits for all results

  // One request as the driver sees it: the fields plus how it is to be offered.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
    int                gap;          // idle cycles before the item is offered
    bit                drain_first;  // offer only once every result has come back
  } deque_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;
  } deque_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  deque_req_t   pending_reqs[$];
  deque_reply_t replies_due[$];
  int           error_count = 0;
  int           items_accepted = 0;

  // Predicted contents of the deque.
  logic [DATA_W-1:0] dq_cells[DQ_DEPTH];
  int                dq_front = 0;
  int                dq_count = 0;

  // Driver state.
  deque_req_t live_req;
  bit         staged = 1'b0;
  int         idle_left = 0;

  // Receiver state.
  int rx_stall = 0;
  int cycle_no = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  bounded_deque_with_search #(.DEPTH(DQ_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the predicted deque and returns the result it should give.
  function automatic deque_reply_t deque_apply(deque_req_t req);
    deque_reply_t r;
    int           slot;
    bit           found;
    r = '{status: STAT_OK, data_out: '0, position: '0, occupancy: '0};
    found = 1'b0;
    case (req.func)
      FN_PUSH_FRONT: begin
        if (dq_count >= DQ_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          dq_front = (dq_front + DQ_DEPTH - 1) % DQ_DEPTH;
          dq_cells[dq_front] = req.value;
          dq_count++;
        end
      end
      FN_PUSH_BACK: begin
        if (dq_count >= DQ_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          dq_cells[(dq_front + dq_count) % DQ_DEPTH] = req.value;
          dq_count++;
        end
      end
      FN_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data_out = dq_cells[dq_front];
          dq_front = (dq_front + 1) % DQ_DEPTH;
          dq_count--;
        end
      end
      FN_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data_out = dq_cells[(dq_front + dq_count - 1) % DQ_DEPTH];
          dq_count--;
        end
      end
      FN_SEARCH: begin
        r.status = STAT_NOTFOUND;
        for (int i = 0; i < dq_count; i++) begin
          slot = (dq_front + i) % DQ_DEPTH;
          if (!found && dq_cells[slot] == req.value) begin
            found = 1'b1;
            r.status = STAT_OK;
            r.data_out = req.value;
            r.position = POS_W'(i);
          end
        end
      end
      default: begin
        // Unused codes leave the deque alone and answer with a plain ok.
      end
    endcase
    r.occupancy = OCC_W'(dq_count);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values that sit at the edges of the signed range, or that recur often.
  function automatic logic [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return 32'h55AA_55AA;
    endcase
  endfunction

  task automatic report(string msg);
    error_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic add_req(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value, int gap,
                         bit drain_first);
    deque_req_t req;
    req.func = func;
    req.value = value;
    req.gap = gap;
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endtask

  // Driver: presents the queued items one at a time, each after its own gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      staged = 1'b0;
      idle_left = 0;
    end else begin : drive
      bit offering;
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        replies_due.push_back(deque_apply(live_req));
        items_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (!staged && pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain_first && replies_due.size() != 0)) begin
          live_req = pending_reqs.pop_front();
          idle_left = live_req.gap;
          staged = 1'b1;
        end
        if (staged && idle_left == 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {{(40 - FUNC_W - DATA_W){1'b0}}, live_req.value, live_req.func};
          staged = 1'b0;
        end else begin
          s_tvalid <= 1'b0;
          if (staged) idle_left--;
        end
      end
    end
  end

  // Long receiver hold-off, so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each result against the oldest prediction and paces m_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
      cycle_no = 0;
    end else begin : watch
      deque_reply_t got;
      deque_reply_t want;
      cycle_no++;
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.data_out = m_tdata[33:2];
        got.position = m_tdata[37:34];
        got.occupancy = m_tdata[42:38];
        if (replies_due.size() == 0) begin
          report($sformatf("result with nothing outstanding: %h", m_tdata));
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
          if (got.data_out !== want.data_out)
            report($sformatf("data_out %h, predicted %h", got.data_out, want.data_out));
          if (got.position !== want.position)
            report($sformatf("position %0d, predicted %0d", got.position, want.position));
          if (got.occupancy !== want.occupancy)
            report($sformatf("occupancy %0d, predicted %0d", got.occupancy,
                             want.occupancy));
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
        // In every fourth window of the cycle count the receiver draws no random stalls.
        if ((cycle_no / 256) % 4 != 1) rx_stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] recent_vals[$];
    logic [DATA_W-1:0] v;
    logic [FUNC_W-1:0] f;
    int n;
    int seg_len;
    int push_pct;
    int search_pct;
    int r;
    int gap;
    bit calm;

    // Directed: an empty deque first, then the edges of the value range.
    add_req(FN_POP_FRONT, 32'h1234_5678, 0, 1'b0);
    add_req(FN_POP_BACK, 32'hFFFF_FFFF, 0, 1'b0);
    add_req(FN_SEARCH, 32'h0000_0000, 0, 1'b0);
    add_req(FN_PUSH_FRONT, 32'h8000_0000, 0, 1'b0);
    add_req(FN_PUSH_BACK, 32'h7FFF_FFFF, 0, 1'b0);
    add_req(FN_PUSH_BACK, 32'hFFFF_FFFF, 0, 1'b0);
    add_req(FN_PUSH_FRONT, 32'h0000_0000, 0, 1'b0);
    add_req(FN_PUSH_BACK, 32'h7FFF_FFFF, 0, 1'b0);
    // The first match from the front wins when a value is held twice.
    add_req(FN_SEARCH, 32'h7FFF_FFFF, 0, 1'b0);
    add_req(FN_SEARCH, 32'h0000_0000, 0, 1'b0);
    add_req(FN_SEARCH, 32'h8000_0001, 0, 1'b0);
    add_req(3'd5, 32'hA5A5_A5A5, 0, 1'b0);
    add_req(3'd6, 32'h5A5A_5A5A, 0, 1'b0);
    add_req(3'd7, 32'hFFFF_FFFF, 0, 1'b0);
    add_req(FN_POP_FRONT, 32'h0000_0000, 0, 1'b0);
    add_req(FN_POP_BACK, 32'h0000_0000, 0, 1'b0);
    add_req(FN_SEARCH, 32'h7FFF_FFFF, 0, 1'b0);
    add_req(FN_POP_BACK, 32'h0000_0000, 0, 1'b0);
    add_req(FN_POP_FRONT, 32'h0000_0000, 0, 1'b0);
    add_req(FN_POP_FRONT, 32'h0000_0000, 0, 1'b0);
    add_req(FN_POP_BACK, 32'h0000_0000, 0, 1'b0);
    add_req(FN_SEARCH, 32'hFFFF_FFFF, 0, 1'b0);

    // Random: segments that lean towards filling, draining, searching or neither,
    // so that the deque runs into full and empty over and over.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      seg_len = $urandom_range(15, 50);
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin push_pct = 65; search_pct = 20; end
        1: begin push_pct = 25; search_pct = 20; end
        2: begin push_pct = 40; search_pct = 45; end
        default: begin push_pct = 35; search_pct = 30; end
      endcase
      for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          f = 3'($urandom_range(5, 7));
          v = $urandom;
        end else if (r < 3 + push_pct) begin
          f = ($urandom_range(0, 1) == 0) ? FN_PUSH_FRONT : FN_PUSH_BACK;
          v = ($urandom_range(0, 9) < 3) ? pool_value() : 32'($urandom);
          recent_vals.push_back(v);
          if (recent_vals.size() > DQ_DEPTH) void'(recent_vals.pop_front());
        end else if (r < 3 + push_pct + search_pct) begin
          f = FN_SEARCH;
          r = $urandom_range(0, 3);
          if (r < 2 && recent_vals.size() != 0)
            v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
          else if (r == 2)
            v = pool_value();
          else
            v = $urandom;
        end else begin
          f = ($urandom_range(0, 1) == 0) ? FN_POP_FRONT : FN_POP_BACK;
          v = $urandom;
        end
        gap = calm ? 0 : pick_gap();
        add_req(f, v, gap, n == DRAIN_AT);
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || staged || replies_due.size() != 0)
      @(posedge clk);
    // Idle clocks at the end, to catch anything spurious.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
